>>> src/c8ie_pkg.sv
// ----------------------------------------------------------------------------
// c8ie_pkg
// Shared types, constants and the font table of the CHIP-8 instruction
// executor.
// ----------------------------------------------------------------------------
package c8ie_pkg;

  // memory and display geometry
  localparam int MemBytes = 4096;
  localparam int MemAw    = $clog2(MemBytes);
  localparam int ScreenW  = 64;
  localparam int ScreenH  = 32;
  localparam int ScrXw    = $clog2(ScreenW);
  localparam int ScrYw    = $clog2(ScreenH);
  localparam int FontLen  = 80;
  localparam int FontCw   = $clog2(FontLen);

  // item operation codes
  localparam logic [1:0] OpMemWrite = 2'd0;
  localparam logic [1:0] OpStep     = 2'd1;
  localparam logic [1:0] OpPixel    = 2'd2;

  // opcode classes (top nibble)
  localparam logic [3:0] OpcSystem = 4'h0;
  localparam logic [3:0] OpcJump   = 4'h1;
  localparam logic [3:0] OpcSetV   = 4'h6;
  localparam logic [3:0] OpcAddV   = 4'h7;
  localparam logic [3:0] OpcSetI   = 4'hA;
  localparam logic [3:0] OpcDraw   = 4'hD;

  localparam logic [15:0] OpcClearScreen = 16'h00E0;
  localparam logic [11:0] PcReset        = 12'h200;
  localparam logic [11:0] FontBase       = 12'h050;
  localparam logic [3:0]  FlagReg        = 4'hF;

  // sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_EXEC,
    ST_CLEAR,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_PIXEL,
    ST_RESP
  } c8ie_state_e;

  // display row commands
  typedef enum logic [1:0] {
    SCR_IDLE,
    SCR_READ,
    SCR_CLEAR,
    SCR_XOR
  } c8ie_scr_cmd_e;

  typedef struct packed {
    c8ie_scr_cmd_e      cmd;
    logic [ScrYw-1:0]   row;
    logic [7:0]         sprite;
    logic [ScrXw-1:0]   x0;
  } c8ie_scr_req_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] address;
    logic [7:0]  data_byte;
    logic [5:0]  pixel_x;
    logic [4:0]  pixel_y;
  } c8ie_item_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [11:0] index_value;
    logic [7:0]  flag_value;
    logic        pixel_on;
    logic        unknown_opcode;
    logic        step_skipped;
  } c8ie_result_t;

  // font glyphs 0..F, five bytes each
  function automatic logic [7:0] font_byte(input logic [FontCw-1:0] idx);
    logic [7:0] b;
    case (idx)
      7'd0:  b = 8'hF0;  7'd1:  b = 8'h90;  7'd2:  b = 8'h90;  7'd3:  b = 8'h90;
      7'd4:  b = 8'hF0;  7'd5:  b = 8'h20;  7'd6:  b = 8'h60;  7'd7:  b = 8'h20;
      7'd8:  b = 8'h20;  7'd9:  b = 8'h70;  7'd10: b = 8'hF0;  7'd11: b = 8'h10;
      7'd12: b = 8'hF0;  7'd13: b = 8'h80;  7'd14: b = 8'hF0;  7'd15: b = 8'hF0;
      7'd16: b = 8'h10;  7'd17: b = 8'hF0;  7'd18: b = 8'h10;  7'd19: b = 8'hF0;
      7'd20: b = 8'h90;  7'd21: b = 8'h90;  7'd22: b = 8'hF0;  7'd23: b = 8'h10;
      7'd24: b = 8'h10;  7'd25: b = 8'hF0;  7'd26: b = 8'h80;  7'd27: b = 8'hF0;
      7'd28: b = 8'h10;  7'd29: b = 8'hF0;  7'd30: b = 8'hF0;  7'd31: b = 8'h80;
      7'd32: b = 8'hF0;  7'd33: b = 8'h90;  7'd34: b = 8'hF0;  7'd35: b = 8'hF0;
      7'd36: b = 8'h10;  7'd37: b = 8'h20;  7'd38: b = 8'h40;  7'd39: b = 8'h40;
      7'd40: b = 8'hF0;  7'd41: b = 8'h90;  7'd42: b = 8'hF0;  7'd43: b = 8'h90;
      7'd44: b = 8'hF0;  7'd45: b = 8'hF0;  7'd46: b = 8'h90;  7'd47: b = 8'hF0;
      7'd48: b = 8'h10;  7'd49: b = 8'hF0;  7'd50: b = 8'hF0;  7'd51: b = 8'h90;
      7'd52: b = 8'hF0;  7'd53: b = 8'h90;  7'd54: b = 8'h90;  7'd55: b = 8'hE0;
      7'd56: b = 8'h90;  7'd57: b = 8'hE0;  7'd58: b = 8'h90;  7'd59: b = 8'hE0;
      7'd60: b = 8'hF0;  7'd61: b = 8'h80;  7'd62: b = 8'h80;  7'd63: b = 8'h80;
      7'd64: b = 8'hF0;  7'd65: b = 8'hE0;  7'd66: b = 8'h90;  7'd67: b = 8'h90;
      7'd68: b = 8'h90;  7'd69: b = 8'hE0;  7'd70: b = 8'hF0;  7'd71: b = 8'h80;
      7'd72: b = 8'hF0;  7'd73: b = 8'h80;  7'd74: b = 8'hF0;  7'd75: b = 8'hF0;
      7'd76: b = 8'h80;  7'd77: b = 8'hF0;  7'd78: b = 8'h80;  7'd79: b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> src/chip8_instruction_executor_top.sv
// ----------------------------------------------------------------------------
// chip8_instruction_executor_top
// CHIP-8 subset core: byte memory, 64x32 display, V0..VF, pc and index,
// run by a small sequencer around one memory port and one row draw unit.
// ----------------------------------------------------------------------------
//  channel   signals                        transfer
//  item      start, busy, item_i            start high and busy low
//  result    done_o, result_o               done_o high, one cycle, no stall
//  config    cfg_valid_i, cfg_ready_o,      cfg_valid_i and cfg_ready_o high
//            cfg_data_i
//
// After reset the font is copied into memory while busy is high.
// Memory write and pixel read end in a result strobe. A step fetches and
// executes, then clears the screen (one row a cycle) or draws sprite rows.
// The single memory read port sets the fetch and sprite row pace.
// Each result is shown one cycle on done_o; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module chip8_instruction_executor_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  c8ie_pkg::c8ie_item_t   item_i,
  output logic                   done_o,
  output c8ie_pkg::c8ie_result_t result_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i
);

  c8ie_pkg::c8ie_state_e state_q, state_d;

  logic [11:0] pc_q, pc_d;
  logic [11:0] idx_q, idx_d;
  logic [7:0]  v_q [16];
  logic [7:0]  v_d [16];
  logic [15:0] opcode_q, opcode_d;
  logic [7:0]  op_hi_q, op_hi_d;
  logic [c8ie_pkg::FontCw-1:0] font_cnt_q, font_cnt_d;
  logic [c8ie_pkg::ScrYw-1:0]  step_cnt_q, step_cnt_d;
  logic [c8ie_pkg::ScrXw-1:0]  x0_q, x0_d;
  logic [c8ie_pkg::ScrYw-1:0]  y0_q, y0_d;
  logic [c8ie_pkg::ScrXw-1:0]  px_q, px_d;
  logic        loaded_q;
  logic        pixel_q, pixel_d;
  logic        unknown_q, unknown_d;
  logic        skipped_q, skipped_d;
  logic        done_q, done_d;
  c8ie_pkg::c8ie_result_t result_q, result_d;

  logic                        ram_we;
  logic [c8ie_pkg::MemAw-1:0]  ram_waddr;
  logic [7:0]                  ram_wdata;
  logic [c8ie_pkg::MemAw-1:0]  ram_raddr;
  logic [7:0]                  ram_rdata;

  c8ie_pkg::c8ie_scr_req_t      scr_req;
  logic [c8ie_pkg::ScreenW-1:0] scr_rd;
  logic                         scr_collision;

  logic [c8ie_pkg::ScrYw:0] draw_y;
  logic                     draw_end;
  logic                     item_xfer;

  assign busy        = (state_q != c8ie_pkg::ST_IDLE);
  assign item_xfer   = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign result_o    = result_q;

  // sprite row position and end of draw: row count reached or bottom edge
  assign draw_y   = {1'b0, y0_q} + {2'b00, step_cnt_q[3:0]};
  assign draw_end = (step_cnt_q[3:0] == opcode_q[3:0]) || draw_y[c8ie_pkg::ScrYw];

  c8ie_ram #(
    .Depth (c8ie_pkg::MemBytes),
    .Width (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  c8ie_screen u_screen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (scr_req),
    .rd_data_o   (scr_rd),
    .collision_o (scr_collision)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      c8ie_pkg::ST_INIT: begin
        if (font_cnt_q == c8ie_pkg::FontCw'(c8ie_pkg::FontLen - 1)) begin
          state_d = c8ie_pkg::ST_IDLE;
        end
      end
      c8ie_pkg::ST_IDLE: begin
        if (item_xfer) begin
          if (item_i.operation == c8ie_pkg::OpStep && loaded_q) begin
            state_d = c8ie_pkg::ST_FETCH_HI;
          end else if (item_i.operation == c8ie_pkg::OpPixel) begin
            state_d = c8ie_pkg::ST_PIXEL;
          end else begin
            state_d = c8ie_pkg::ST_RESP;
          end
        end
      end
      c8ie_pkg::ST_FETCH_HI: state_d = c8ie_pkg::ST_FETCH_LO;
      c8ie_pkg::ST_FETCH_LO: state_d = c8ie_pkg::ST_EXEC;
      c8ie_pkg::ST_EXEC: begin
        if (opcode_q == c8ie_pkg::OpcClearScreen) begin
          state_d = c8ie_pkg::ST_CLEAR;
        end else if (opcode_q[15:12] == c8ie_pkg::OpcDraw) begin
          state_d = c8ie_pkg::ST_DRAW_RD;
        end else begin
          state_d = c8ie_pkg::ST_RESP;
        end
      end
      c8ie_pkg::ST_CLEAR: begin
        if (step_cnt_q == c8ie_pkg::ScrYw'(c8ie_pkg::ScreenH - 1)) begin
          state_d = c8ie_pkg::ST_RESP;
        end
      end
      c8ie_pkg::ST_DRAW_RD: state_d = draw_end ? c8ie_pkg::ST_RESP : c8ie_pkg::ST_DRAW_WR;
      c8ie_pkg::ST_DRAW_WR: state_d = c8ie_pkg::ST_DRAW_RD;
      c8ie_pkg::ST_PIXEL:   state_d = c8ie_pkg::ST_RESP;
      c8ie_pkg::ST_RESP:    state_d = c8ie_pkg::ST_IDLE;
      default:              state_d = c8ie_pkg::ST_IDLE;
    endcase
  end

  // datapath control and register updates
  always_comb begin
    pc_d       = pc_q;
    idx_d      = idx_q;
    v_d        = v_q;
    opcode_d   = opcode_q;
    op_hi_d    = op_hi_q;
    font_cnt_d = font_cnt_q;
    step_cnt_d = step_cnt_q;
    x0_d       = x0_q;
    y0_d       = y0_q;
    px_d       = px_q;
    pixel_d    = pixel_q;
    unknown_d  = unknown_q;
    skipped_d  = skipped_q;
    done_d     = 1'b0;
    result_d   = result_q;

    ram_we     = 1'b0;
    ram_waddr  = item_i.address[c8ie_pkg::MemAw-1:0];
    ram_wdata  = item_i.data_byte;
    ram_raddr  = pc_q[c8ie_pkg::MemAw-1:0];

    scr_req.cmd    = c8ie_pkg::SCR_IDLE;
    scr_req.row    = draw_y[c8ie_pkg::ScrYw-1:0];
    scr_req.sprite = ram_rdata;
    scr_req.x0     = x0_q;

    case (state_q)
      // font copy after reset
      c8ie_pkg::ST_INIT: begin
        ram_we     = 1'b1;
        ram_waddr  = c8ie_pkg::FontBase[c8ie_pkg::MemAw-1:0]
                     + c8ie_pkg::MemAw'(font_cnt_q);
        ram_wdata  = c8ie_pkg::font_byte(font_cnt_q);
        font_cnt_d = font_cnt_q + 1'b1;
      end
      // item transfer: memory write or pixel row read starts right away
      c8ie_pkg::ST_IDLE: begin
        if (item_xfer) begin
          pixel_d   = 1'b0;
          unknown_d = 1'b0;
          skipped_d = 1'b0;
          case (item_i.operation)
            c8ie_pkg::OpMemWrite: ram_we = 1'b1;
            c8ie_pkg::OpStep:     skipped_d = !loaded_q;
            c8ie_pkg::OpPixel: begin
              scr_req.cmd = c8ie_pkg::SCR_READ;
              scr_req.row = item_i.pixel_y;
              px_d        = item_i.pixel_x;
            end
            default: ;
          endcase
        end
      end
      // opcode fetch, high byte then low byte
      c8ie_pkg::ST_FETCH_HI: begin
        ram_raddr = c8ie_pkg::MemAw'(pc_q + 12'd1);
        op_hi_d   = ram_rdata;
      end
      c8ie_pkg::ST_FETCH_LO: begin
        opcode_d = {op_hi_q, ram_rdata};
        pc_d     = pc_q + 12'd2;
      end
      // decode and execute
      c8ie_pkg::ST_EXEC: begin
        step_cnt_d = '0;
        case (opcode_q[15:12])
          c8ie_pkg::OpcSystem: ;
          c8ie_pkg::OpcJump:   pc_d = opcode_q[11:0];
          c8ie_pkg::OpcSetV:   v_d[opcode_q[11:8]] = opcode_q[7:0];
          c8ie_pkg::OpcAddV:   v_d[opcode_q[11:8]] = v_q[opcode_q[11:8]] + opcode_q[7:0];
          c8ie_pkg::OpcSetI:   idx_d = opcode_q[11:0];
          c8ie_pkg::OpcDraw: begin
            x0_d = v_q[opcode_q[11:8]][c8ie_pkg::ScrXw-1:0];
            y0_d = v_q[opcode_q[7:4]][c8ie_pkg::ScrYw-1:0];
            v_d[c8ie_pkg::FlagReg] = 8'd0;
          end
          default: unknown_d = 1'b1;
        endcase
      end
      // screen clear, one row a cycle
      c8ie_pkg::ST_CLEAR: begin
        scr_req.cmd = c8ie_pkg::SCR_CLEAR;
        scr_req.row = step_cnt_q;
        step_cnt_d  = step_cnt_q + 1'b1;
      end
      // sprite row: read display row and sprite byte together
      c8ie_pkg::ST_DRAW_RD: begin
        if (!draw_end) begin
          scr_req.cmd = c8ie_pkg::SCR_READ;
          ram_raddr   = c8ie_pkg::MemAw'(idx_q + {8'd0, step_cnt_q[3:0]});
        end
      end
      // sprite row: XOR back and note any collision
      c8ie_pkg::ST_DRAW_WR: begin
        scr_req.cmd = c8ie_pkg::SCR_XOR;
        if (scr_collision) begin
          v_d[c8ie_pkg::FlagReg] = 8'd1;
        end
        step_cnt_d = step_cnt_q + 1'b1;
      end
      c8ie_pkg::ST_PIXEL: begin
        pixel_d = scr_rd[px_q];
      end
      // result strobe
      c8ie_pkg::ST_RESP: begin
        done_d                   = 1'b1;
        result_d.program_counter = pc_q;
        result_d.index_value     = idx_q;
        result_d.flag_value      = v_q[c8ie_pkg::FlagReg];
        result_d.pixel_on        = pixel_q;
        result_d.unknown_opcode  = unknown_q;
        result_d.step_skipped    = skipped_q;
      end
      default: ;
    endcase
  end

  // control and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= c8ie_pkg::ST_INIT;
      pc_q       <= c8ie_pkg::PcReset;
      idx_q      <= '0;
      for (int r = 0; r < 16; r++) begin
        v_q[r] <= '0;
      end
      font_cnt_q <= '0;
      step_cnt_q <= '0;
      loaded_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      pc_q       <= pc_d;
      idx_q      <= idx_d;
      v_q        <= v_d;
      font_cnt_q <= font_cnt_d;
      step_cnt_q <= step_cnt_d;
      done_q     <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        loaded_q <= cfg_data_i;
      end
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    opcode_q  <= opcode_d;
    op_hi_q   <= op_hi_d;
    x0_q      <= x0_d;
    y0_q      <= y0_d;
    px_q      <= px_d;
    pixel_q   <= pixel_d;
    unknown_q <= unknown_d;
    skipped_q <= skipped_d;
    result_q  <= result_d;
  end

endmodule

>>> src/c8ie_ram.sv
// ----------------------------------------------------------------------------
// c8ie_ram
// Single-port-write, single-port-read byte RAM with registered read data.
// ----------------------------------------------------------------------------
module c8ie_ram #(
  parameter int Depth = 4096,
  parameter int Width = 8,
  parameter int Aw    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> src/c8ie_screen.sv
// ----------------------------------------------------------------------------
// c8ie_screen
// Display row store with the row draw unit: registered row read, row clear,
// and clipped sprite XOR with collision detect on the last row read.
// ----------------------------------------------------------------------------
module c8ie_screen (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  c8ie_pkg::c8ie_scr_req_t      req_i,
  output logic [c8ie_pkg::ScreenW-1:0] rd_data_o,
  output logic                         collision_o
);

  logic [c8ie_pkg::ScreenW-1:0] rows_q [c8ie_pkg::ScreenH];
  logic [c8ie_pkg::ScreenW-1:0] rd_q;
  logic [7:0]                   sprite_rev;
  logic [c8ie_pkg::ScreenW-1:0] mask;

  // sprite bit 7 lands on x0, bit 0 on x0+7; the shift drops pixels past
  // the right edge
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      sprite_rev[j] = req_i.sprite[7-j];
    end
    mask = {{(c8ie_pkg::ScreenW-8){1'b0}}, sprite_rev} << req_i.x0;
  end

  assign collision_o = |(rd_q & mask);
  assign rd_data_o   = rd_q;

  // row store, even rows lit after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < c8ie_pkg::ScreenH; r++) begin
        rows_q[r] <= (r % 2 == 0) ? '1 : '0;
      end
    end else begin
      case (req_i.cmd)
        c8ie_pkg::SCR_CLEAR: rows_q[req_i.row] <= '0;
        c8ie_pkg::SCR_XOR:   rows_q[req_i.row] <= rd_q ^ mask;
        default: ;
      endcase
    end
  end

  // read register
  always_ff @(posedge clk_i) begin
    if (req_i.cmd == c8ie_pkg::SCR_READ) begin
      rd_q <= rows_q[req_i.row];
    end
  end

endmodule
